FILE: hdl/dlf_pkg.sv
// Shared types, protocol constants and helpers for the display link framer.
`default_nettype none

package dlf_pkg;

    // Input item codes.
    localparam logic [1:0] CMD_START_WRITE = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD     = 2'd1;
    localparam logic [1:0] CMD_START_READ  = 2'd2;
    localparam logic [1:0] CMD_LINK_BYTE   = 2'd3;

    // Result item kinds.
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Link protocol characters.
    localparam logic [7:0] CH_ACK  = 8'h06;
    localparam logic [7:0] CH_DC1  = 8'h11;
    localparam logic [7:0] CH_DC2  = 8'h12;
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_ONE  = 8'h01;
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_POLL = 8'h00;
    localparam logic [7:0] READ_REQ_SUM = CH_DC2 + CH_ONE + CH_S;

    // Most results that one input item can cause.
    localparam int RUN_SLOTS = 5;
    localparam int RUN_CNT_W = $clog2(RUN_SLOTS + 1);
    localparam int RUN_IDX_W = $clog2(RUN_SLOTS);

    // Transaction phase, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_W_DATA = 8'b0000_0010,
        PH_W_ACK  = 8'b0000_0100,
        PH_R_ACK  = 8'b0000_1000,
        PH_R_DC1  = 8'b0001_0000,
        PH_R_LEN  = 8'b0010_0000,
        PH_R_DATA = 8'b0100_0000,
        PH_R_BCC  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] frame_length;
        logic [7:0] data_byte;
        logic       buffer_ready;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       failed;
        logic       last;
    } out_item_t;

    // One result without its last mark.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic       failed;
    } result_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [RUN_CNT_W-1:0]      count;
        result_t [RUN_SLOTS-1:0]   slot;
    } run_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic result_t make_result(logic [1:0] kind, logic [7:0] value,
                                            logic failed);
        result_t r;
        r.kind       = kind;
        r.byte_value = value;
        r.failed     = failed;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dlf_front.sv
// Front part: accepts items, runs the framing state and builds each item's result run.
`default_nettype none

module dlf_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  dlf_pkg::in_item_t      req,
    output dlf_pkg::run_t          run
);

    dlf_pkg::phase_t phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] read_count_reg, read_count_next;

    logic [7:0] len_plus_one;
    logic [7:0] header_sum;
    logic [7:0] payload_sum;
    logic [7:0] bytes_left_dec;

    // Byte arithmetic shared by the branches below.
    assign len_plus_one   = req.frame_length + 8'd1;
    assign header_sum     = dlf_pkg::CH_DC1 + len_plus_one + dlf_pkg::CH_ESC;
    assign payload_sum    = running_sum_reg + req.data_byte;
    assign bytes_left_dec = bytes_left_reg - 8'd1;

    // Next state and the results for the current item.
    always_comb
    begin
        run              = '0;
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        read_count_next  = read_count_reg;

        unique case (req.cmd)
            dlf_pkg::CMD_START_WRITE:
            begin
                running_sum_next = header_sum;
                bytes_left_next  = req.frame_length;
                run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, dlf_pkg::CH_DC1, 1'b0);
                run.slot[1] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, len_plus_one, 1'b0);
                run.slot[2] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, dlf_pkg::CH_ESC, 1'b0);
                if (req.frame_length == 8'd0)
                begin
                    // Empty write sends the trailer at once.
                    run.slot[3] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, header_sum, 1'b0);
                    run.slot[4] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                       dlf_pkg::CH_POLL, 1'b0);
                    run.count   = dlf_pkg::RUN_CNT_W'(5);
                    phase_next  = dlf_pkg::PH_W_ACK;
                end
                else
                begin
                    run.count  = dlf_pkg::RUN_CNT_W'(3);
                    phase_next = dlf_pkg::PH_W_DATA;
                end
            end

            dlf_pkg::CMD_PAYLOAD:
            begin
                // Payload bytes outside the payload phase are dropped.
                if (phase_reg == dlf_pkg::PH_W_DATA)
                begin
                    running_sum_next = payload_sum;
                    bytes_left_next  = bytes_left_dec;
                    run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, req.data_byte,
                                                       1'b0);
                    if (bytes_left_dec == 8'd0)
                    begin
                        run.slot[1] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, payload_sum,
                                                           1'b0);
                        run.slot[2] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                           dlf_pkg::CH_POLL, 1'b0);
                        run.count   = dlf_pkg::RUN_CNT_W'(3);
                        phase_next  = dlf_pkg::PH_W_ACK;
                    end
                    else
                    begin
                        run.count = dlf_pkg::RUN_CNT_W'(1);
                    end
                end
            end

            dlf_pkg::CMD_START_READ:
            begin
                if (!req.buffer_ready)
                begin
                    run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_DONE, 8'd0, 1'b0);
                    run.count   = dlf_pkg::RUN_CNT_W'(1);
                    phase_next  = dlf_pkg::PH_IDLE;
                end
                else
                begin
                    run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, dlf_pkg::CH_DC2, 1'b0);
                    run.slot[1] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, dlf_pkg::CH_ONE, 1'b0);
                    run.slot[2] = dlf_pkg::make_result(dlf_pkg::KIND_SEND, dlf_pkg::CH_S, 1'b0);
                    run.slot[3] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                       dlf_pkg::READ_REQ_SUM, 1'b0);
                    run.slot[4] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                       dlf_pkg::CH_POLL, 1'b0);
                    run.count   = dlf_pkg::RUN_CNT_W'(5);
                    phase_next  = dlf_pkg::PH_R_ACK;
                end
            end

            dlf_pkg::CMD_LINK_BYTE:
            begin
                unique case (phase_reg)
                    dlf_pkg::PH_IDLE, dlf_pkg::PH_W_DATA:
                    begin
                        // A received byte here ends any write in progress and causes no result.
                        phase_next = dlf_pkg::PH_IDLE;
                    end

                    dlf_pkg::PH_W_ACK:
                    begin
                        run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_DONE, 8'd0,
                                                           req.data_byte != dlf_pkg::CH_ACK);
                        run.count   = dlf_pkg::RUN_CNT_W'(1);
                        phase_next  = dlf_pkg::PH_IDLE;
                    end

                    dlf_pkg::PH_R_ACK, dlf_pkg::PH_R_DC1:
                    begin
                        run.count = dlf_pkg::RUN_CNT_W'(1);
                        if ((phase_reg == dlf_pkg::PH_R_ACK && req.data_byte != dlf_pkg::CH_ACK)
                            || (phase_reg == dlf_pkg::PH_R_DC1
                                && req.data_byte != dlf_pkg::CH_DC1))
                        begin
                            run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_DONE, 8'd0, 1'b0);
                            phase_next  = dlf_pkg::PH_IDLE;
                        end
                        else
                        begin
                            run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                               dlf_pkg::CH_POLL, 1'b0);
                            phase_next  = (phase_reg == dlf_pkg::PH_R_ACK) ?
                                          dlf_pkg::PH_R_DC1 : dlf_pkg::PH_R_LEN;
                        end
                    end

                    dlf_pkg::PH_R_LEN:
                    begin
                        read_count_next = req.data_byte;
                        bytes_left_next = req.data_byte;
                        run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                           dlf_pkg::CH_POLL, 1'b0);
                        run.count   = dlf_pkg::RUN_CNT_W'(1);
                        phase_next  = (req.data_byte == 8'd0) ?
                                      dlf_pkg::PH_R_BCC : dlf_pkg::PH_R_DATA;
                    end

                    dlf_pkg::PH_R_DATA:
                    begin
                        bytes_left_next = bytes_left_dec;
                        run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_DATA, req.data_byte,
                                                           1'b0);
                        run.slot[1] = dlf_pkg::make_result(dlf_pkg::KIND_SEND,
                                                           dlf_pkg::CH_POLL, 1'b0);
                        run.count   = dlf_pkg::RUN_CNT_W'(2);
                        if (bytes_left_dec == 8'd0)
                        begin
                            phase_next = dlf_pkg::PH_R_BCC;
                        end
                    end

                    dlf_pkg::PH_R_BCC:
                    begin
                        // The received checksum byte is not checked.
                        run.slot[0] = dlf_pkg::make_result(dlf_pkg::KIND_DONE, read_count_reg,
                                                           1'b0);
                        run.count   = dlf_pkg::RUN_CNT_W'(1);
                        phase_next  = dlf_pkg::PH_IDLE;
                    end

                    default:
                    begin
                        phase_next = dlf_pkg::PH_IDLE;
                    end
                endcase
            end

            default:
            begin
                phase_next = dlf_pkg::PH_IDLE;
            end
        endcase
    end

    // State registers advance only on an accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= dlf_pkg::PH_IDLE;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            read_count_reg  <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            read_count_reg  <= read_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dlf_queue.sv
// Short queue of result runs between the front and the back parts.
`default_nettype none

module dlf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  dlf_pkg::run_t          push_run,
    input  wire logic              pop,
    output dlf_pkg::run_t          head_run,
    output dlf_pkg::queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dlf_pkg::run_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_run     = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_run;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/dlf_back.sv
// Back part: walks each queued run and sends its results one item per cycle while rsp is not stalled.
`default_nettype none

module dlf_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  dlf_pkg::run_t          head_run,
    input  dlf_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output dlf_pkg::out_item_t     rsp
);

    logic [dlf_pkg::RUN_IDX_W-1:0] idx_reg;
    logic                          out_valid_reg;
    dlf_pkg::out_item_t            out_reg;
    logic                          load;
    logic                          at_last;
    dlf_pkg::result_t              cur;

    // The output register reloads when it is empty or being taken.
    assign load    = !out_valid_reg || !rsp_stall;
    assign cur     = head_run.slot[idx_reg];
    assign at_last = (dlf_pkg::RUN_CNT_W'(idx_reg) + 1'b1 == head_run.count);
    assign pop     = load && !status.empty && at_last;

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load && !status.empty)
        begin
            out_reg.kind       <= cur.kind;
            out_reg.byte_value <= cur.byte_value;
            out_reg.failed     <= cur.failed;
            out_reg.last       <= at_last;
        end
    end

    // Run position and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= !status.empty;
            if (!status.empty)
            begin
                idx_reg <= at_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/display_link_framer_top.sv
// Top level of the display link framer: front, run queue and back.
//
// Usage: the req channel takes one item per cycle (start write, payload byte,
// start read, or a byte received on the link) under req_valid/req_stall. The
// rsp channel returns the resulting items (bytes to send, read data bytes and
// completions) under rsp_valid/rsp_stall; the last item of each input's run
// carries the last mark. An input that causes no result produces nothing.
// The first result of an item passes through a queue entry and then the output register.
// Throughput: one input item per cycle while the queue has room, and one result
// item per cycle while rsp is not stalled; an input that causes several results
// holds the rsp side until all are sent, which is what bounds the sustained rate.
// The queue holds QUEUE_DEPTH runs; req_stall rises only when it is full,
// so input keeps flowing while rsp is stalled until the queue fills.
// Reset clears the framing state to idle and empties the queue and output.
// A stalled rsp item holds its value until taken.
`default_nettype none

module display_link_framer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  dlf_pkg::in_item_t  req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dlf_pkg::out_item_t rsp
);

    dlf_pkg::run_t          new_run;
    dlf_pkg::run_t          head_run;
    dlf_pkg::queue_status_t q_status;
    logic                   accept;
    logic                   push;
    logic                   pop;

    // Input is taken whenever the queue has room.
    assign req_stall = q_status.full;
    assign accept    = req_valid && !q_status.full;
    assign push      = accept && (new_run.count != '0);

    dlf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .run    (new_run)
    );

    dlf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (new_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (q_status)
    );

    dlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_run  (head_run),
        .status    (q_status),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // The queue cannot report full and empty together.
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    // A run is retired only while the queue holds one.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A run that was pushed into an empty queue reaches the output through the queue entry and the output register.
    a_push_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (push && q_status.empty && (!rsp_valid || !rsp_stall)) |=> ##1 rsp_valid)
        else $error("pushed run did not reach the output");

    // Result kinds stay within send, data and completion.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.kind == dlf_pkg::KIND_SEND || rsp.kind == dlf_pkg::KIND_DATA
                       || rsp.kind == dlf_pkg::KIND_DONE))
        else $error("illegal result kind");

endmodule

`default_nettype wire
